@@ design/gwtu_pkg.sv @@
`timescale 1ns / 1ps
// gwtu_pkg: widths, calendar constants and reciprocal divider constants
// for the GPS week time to UTC date pipeline. No dependencies.

package gwtu_pkg;

	localparam int TIME_SECOND_DENOM = 1000;
	localparam int TOW_FRACTION_BITS = 12;

	localparam int SECS_PER_WEEK = 604800;
	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;
	localparam int JD_EPOCH      = 2447892;

	// port widths
	localparam int WS_W   = 32;
	localparam int WSD_W  = 16;
	localparam int LEAP_W = 8;
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int SU_W   = 16;
	localparam int YEAR_W = 12;
	localparam int MON_W  = 4;
	localparam int DOM_W  = 5;

	// sub-second rounding
	localparam int TOW_ONE = 1 << TOW_FRACTION_BITS;
	localparam int TOW_UNIT = 2 * TIME_SECOND_DENOM * TOW_ONE;
	localparam int LOW_W = $clog2(2 * TOW_UNIT);
	localparam int FRAC_W = $clog2(TIME_SECOND_DENOM + 1);
	localparam int WHOLE_W = WS_W - TOW_FRACTION_BITS + 1;

	// internal widths
	localparam int SECS_W = 20;
	localparam int SD_W   = WHOLE_W + 2;
	localparam int DNUM_W = 18;
	localparam int DQ_W   = 3;
	localparam int SREM_W = 17;
	localparam int HREM_W = 12;
	localparam int SINT_W = 6;
	localparam int JD_W   = 22;
	localparam int JDX_W  = JD_W + 1;
	localparam int WN_W   = 22;
	localparam int W_W    = 5;
	localparam int B_W    = 22;
	localparam int CN_W   = 26;
	localparam int C_W    = 13;
	localparam int DP_W   = 24;
	localparam int BD_W   = 10;
	localparam int EN_W   = 24;
	localparam int E_W    = 4;
	localparam int P_W    = 23;
	localparam int F_W    = 9;

	// Reciprocal constants: quotient = (n * M) >> SH, exact for every n below 2^N
	// when SH = N + ceil(log2(divisor)) and M = ceil(2^SH / divisor).
	localparam int DIV_DAY_SH = SECS_W + $clog2(SECS_PER_DAY);
	localparam longint unsigned DIV_DAY_M =
		((64'd1 << DIV_DAY_SH) + SECS_PER_DAY - 1) / SECS_PER_DAY;
	localparam int DIV_DAY_PW = SECS_W + $clog2(DIV_DAY_M + 1);

	localparam int DIV_HR_SH = SREM_W + $clog2(SECS_PER_HOUR);
	localparam longint unsigned DIV_HR_M =
		((64'd1 << DIV_HR_SH) + SECS_PER_HOUR - 1) / SECS_PER_HOUR;
	localparam int DIV_HR_PW = SREM_W + $clog2(DIV_HR_M + 1);

	localparam int DIV_MIN_SH = HREM_W + $clog2(SECS_PER_MIN);
	localparam longint unsigned DIV_MIN_M =
		((64'd1 << DIV_MIN_SH) + SECS_PER_MIN - 1) / SECS_PER_MIN;
	localparam int DIV_MIN_PW = HREM_W + $clog2(DIV_MIN_M + 1);

	localparam int CENT_DIV = 146097;
	localparam int CENT_OFS = 7468865;
	localparam int DIV_W_SH = WN_W + $clog2(CENT_DIV);
	localparam longint unsigned DIV_W_M = ((64'd1 << DIV_W_SH) + CENT_DIV - 1) / CENT_DIV;
	localparam int DIV_W_PW = WN_W + $clog2(DIV_W_M + 1);

	localparam int YEAR_DIV = 7305;
	localparam int YEAR_OFS = 2442;
	localparam int DIV_C_SH = CN_W + $clog2(YEAR_DIV);
	localparam longint unsigned DIV_C_M = ((64'd1 << DIV_C_SH) + YEAR_DIV - 1) / YEAR_DIV;
	localparam int DIV_C_PW = CN_W + $clog2(DIV_C_M + 1);

	localparam int MON_NUM = 306001;
	localparam int MON_DEN = 10000;
	localparam int DIV_E_SH = EN_W + $clog2(MON_NUM);
	localparam longint unsigned DIV_E_M = ((64'd1 << DIV_E_SH) + MON_NUM - 1) / MON_NUM;
	localparam int DIV_E_PW = EN_W + $clog2(DIV_E_M + 1);

	localparam int DIV_F_SH = P_W + $clog2(MON_DEN);
	localparam longint unsigned DIV_F_M = ((64'd1 << DIV_F_SH) + MON_DEN - 1) / MON_DEN;
	localparam int DIV_F_PW = P_W + $clog2(DIV_F_M + 1);

	localparam int DAYS_4Y = 1461;
	localparam int JD_B_OFS = 1524;
	localparam int YEAR_BASE = 4716;
	localparam int MONTHS = 12;

	localparam int NUM_STAGES = 14;

	typedef struct packed {
		logic [HOUR_W-1:0] hr;
		logic [MIN_W-1:0]  mn;
		logic [SU_W-1:0]   su;
	} tod_t;

endpackage

@@ design/gps_week_time_to_utc_date_unit.sv @@
`timescale 1ns / 1ps
// gps_week_time_to_utc_date_unit: GPS time of week to UTC time of day and date.
// One request per cycle while the output is not stalled by out_ready.
// Each stage holds at most one reciprocal division by a constant (a multiply).
// A stage advances when it is empty or the next stage advances; bubbles collapse.
// Reset (arst_n low) clears only the stage valid bits. Depends on gwtu_pkg.

module gps_week_time_to_utc_date_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [gwtu_pkg::WS_W-1:0]        week_seconds,
	input  logic [gwtu_pkg::WSD_W-1:0]       week_start_day,
	input  logic signed [gwtu_pkg::LEAP_W-1:0] leap_seconds,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [gwtu_pkg::HOUR_W-1:0]      hours,
	output logic [gwtu_pkg::MIN_W-1:0]       minutes,
	output logic [gwtu_pkg::SU_W-1:0]        second_units,
	output logic [gwtu_pkg::YEAR_W-1:0]      year,
	output logic [gwtu_pkg::MON_W-1:0]       month,
	output logic [gwtu_pkg::DOM_W-1:0]       day_of_month
);
	import gwtu_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] adv;

	// stage registers
	logic [WHOLE_W-1:0]  whole_s1;
	logic [FRAC_W-1:0]   frac_s1, frac_s2, frac_s3, frac_s4, frac_s5, frac_s6, frac_s7, frac_s8;
	logic [WSD_W-1:0]    day_s1;
	logic [LEAP_W-1:0]   leap_s1;
	logic [SECS_W-1:0]   secs_s2, secs_s3;
	logic [DNUM_W-1:0]   dnum_s2, dnum_s3;
	logic [DQ_W-1:0]     dq_s3;
	logic [SREM_W-1:0]   srem_s4, srem_s5;
	logic [JD_W-1:0]     jd_s4, jd_s5, jd_s6;
	logic [WN_W-1:0]     wnum_s5;
	logic [HOUR_W-1:0]   hr_s5, hr_s6, hr_s7, hr_s8;
	logic [HREM_W-1:0]   hrem_s6, hrem_s7;
	logic [W_W-1:0]      w_s6;
	logic [MIN_W-1:0]    mn_s7, mn_s8;
	logic [B_W-1:0]      b_s7, b_s8, b_s9;
	logic [SINT_W-1:0]   sint_s8;
	logic [CN_W-1:0]     cnum_s8;
	tod_t                tod_s9, tod_s10, tod_s11, tod_s12, tod_s13, tod_s14;
	logic [C_W-1:0]      c_s9, c_s10, c_s11, c_s12, c_s13;
	logic [BD_W-1:0]     bd_s10, bd_s11, bd_s12, bd_s13;
	logic [EN_W-1:0]     en_s11;
	logic [E_W-1:0]      e_s12, e_s13;
	logic [P_W-1:0]      p_s13;
	logic [YEAR_W-1:0]   year_s14;
	logic [MON_W-1:0]    month_s14;
	logic [DOM_W-1:0]    dom_s14;

	// combinational terms
	logic [LOW_W-1:0]      low, low_rem;
	logic                  low_carry;
	logic [FRAC_W-1:0]     frac_n;
	logic [WHOLE_W-1:0]    whole_n;
	logic                  wk_roll;
	logic [WHOLE_W-1:0]    base;
	logic [SD_W-1:0]       sd;
	logic                  sd_neg;
	logic [SECS_W-1:0]     secs_n;
	logic [DNUM_W-1:0]     dnum_n;
	logic [DIV_DAY_PW-1:0] day_prod;
	logic [JDX_W-1:0]      jdx;
	logic [DIV_HR_PW-1:0]  hr_prod;
	logic [WN_W+1:0]       wnx;
	logic [DIV_MIN_PW-1:0] min_prod;
	logic [DIV_W_PW-1:0]   w_prod;
	logic [B_W-1:0]        b_n;
	logic [DIV_C_PW-1:0]   c_prod;
	logic [DP_W-1:0]       d_prod;
	logic [DIV_E_PW-1:0]   e_prod;
	logic [DIV_F_PW-1:0]   f_prod;
	logic [F_W-1:0]        f_n;
	logic [MON_W-1:0]      mon_raw, mon_n;

	always_comb begin
		adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_comb begin
		// stage 1: whole second and rounded sub-second count
		low = LOW_W'(week_seconds[TOW_FRACTION_BITS-1:0]) * LOW_W'(2 * TIME_SECOND_DENOM)
			+ LOW_W'(TOW_ONE);
		low_carry = low >= LOW_W'(TOW_UNIT);
		low_rem = low_carry ? low - LOW_W'(TOW_UNIT) : low;
		frac_n = FRAC_W'((low_rem + LOW_W'(TOW_ONE)) >> (TOW_FRACTION_BITS + 1));
		whole_n = WHOLE_W'(week_seconds[WS_W-1:TOW_FRACTION_BITS]) + WHOLE_W'(low_carry);

		// stage 2: week rollover, leap seconds, week borrow
		wk_roll = whole_s1 >= WHOLE_W'(SECS_PER_WEEK);
		base = wk_roll ? '0 : whole_s1;
		sd = {2'b00, base} - {{(SD_W - LEAP_W){leap_s1[LEAP_W-1]}}, leap_s1};
		sd_neg = sd[SD_W-1];
		secs_n = sd_neg ? SECS_W'(sd + SD_W'(SECS_PER_WEEK)) : SECS_W'(sd);
		dnum_n = DNUM_W'(day_s1) + (wk_roll ? DNUM_W'(7) : '0) - (sd_neg ? DNUM_W'(7) : '0);

		// stage 3: day carry
		day_prod = DIV_DAY_PW'(secs_s2) * DIV_DAY_PW'(DIV_DAY_M);

		// stage 4: Julian day
		jdx = {{(JDX_W - DNUM_W){dnum_s3[DNUM_W-1]}}, dnum_s3} + JDX_W'(dq_s3)
			+ JDX_W'(JD_EPOCH);

		// stage 5: hour, century numerator
		hr_prod = DIV_HR_PW'(srem_s4) * DIV_HR_PW'(DIV_HR_M);
		wnx = {jd_s4, 2'b00} - (WN_W + 2)'(CENT_OFS);

		// stage 6: century
		w_prod = DIV_W_PW'(wnum_s5) * DIV_W_PW'(DIV_W_M);

		// stage 7: minute, b
		min_prod = DIV_MIN_PW'(hrem_s6) * DIV_MIN_PW'(DIV_MIN_M);
		b_n = jd_s6 + B_W'(1) + B_W'(w_s6) - B_W'(w_s6 >> 2) + B_W'(JD_B_OFS);

		// stage 9: c
		c_prod = DIV_C_PW'(cnum_s8) * DIV_C_PW'(DIV_C_M);

		// stage 10: d
		d_prod = DP_W'(c_s9) * DP_W'(DAYS_4Y);

		// stage 12: e
		e_prod = DIV_E_PW'(en_s11) * DIV_E_PW'(DIV_E_M);

		// stage 14: f, date fields
		f_prod = DIV_F_PW'(p_s13) * DIV_F_PW'(DIV_F_M);
		f_n = f_prod[DIV_F_SH +: F_W];
		mon_raw = e_s13 - MON_W'(1);
		mon_n = (mon_raw > MON_W'(MONTHS)) ? mon_raw - MON_W'(MONTHS) : mon_raw;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			whole_s1 <= whole_n;
			frac_s1  <= frac_n;
			day_s1   <= week_start_day;
			leap_s1  <= leap_seconds;
		end
		if (adv[1]) begin
			secs_s2 <= secs_n;
			dnum_s2 <= dnum_n;
			frac_s2 <= frac_s1;
		end
		if (adv[2]) begin
			dq_s3   <= day_prod[DIV_DAY_SH +: DQ_W];
			secs_s3 <= secs_s2;
			dnum_s3 <= dnum_s2;
			frac_s3 <= frac_s2;
		end
		if (adv[3]) begin
			srem_s4 <= SREM_W'(secs_s3 - SECS_W'(dq_s3) * SECS_W'(SECS_PER_DAY));
			jd_s4   <= jdx[JD_W-1:0];
			frac_s4 <= frac_s3;
		end
		if (adv[4]) begin
			hr_s5   <= hr_prod[DIV_HR_SH +: HOUR_W];
			srem_s5 <= srem_s4;
			wnum_s5 <= wnx[WN_W-1:0];
			jd_s5   <= jd_s4;
			frac_s5 <= frac_s4;
		end
		if (adv[5]) begin
			hrem_s6 <= HREM_W'(srem_s5 - SREM_W'(hr_s5) * SREM_W'(SECS_PER_HOUR));
			w_s6    <= w_prod[DIV_W_SH +: W_W];
			jd_s6   <= jd_s5;
			hr_s6   <= hr_s5;
			frac_s6 <= frac_s5;
		end
		if (adv[6]) begin
			mn_s7   <= min_prod[DIV_MIN_SH +: MIN_W];
			hrem_s7 <= hrem_s6;
			b_s7    <= b_n;
			hr_s7   <= hr_s6;
			frac_s7 <= frac_s6;
		end
		if (adv[7]) begin
			sint_s8 <= SINT_W'(hrem_s7 - HREM_W'(mn_s7) * HREM_W'(SECS_PER_MIN));
			cnum_s8 <= CN_W'(b_s7) * CN_W'(20) - CN_W'(YEAR_OFS);
			b_s8    <= b_s7;
			hr_s8   <= hr_s7;
			mn_s8   <= mn_s7;
			frac_s8 <= frac_s7;
		end
		if (adv[8]) begin
			tod_s9.hr <= hr_s8;
			tod_s9.mn <= mn_s8;
			tod_s9.su <= SU_W'(sint_s8) * SU_W'(TIME_SECOND_DENOM) + SU_W'(frac_s8);
			c_s9      <= c_prod[DIV_C_SH +: C_W];
			b_s9      <= b_s8;
		end
		if (adv[9]) begin
			bd_s10  <= BD_W'(b_s9 - B_W'(d_prod[DP_W-1:2]));
			c_s10   <= c_s9;
			tod_s10 <= tod_s9;
		end
		if (adv[10]) begin
			en_s11  <= EN_W'(bd_s10) * EN_W'(MON_DEN);
			bd_s11  <= bd_s10;
			c_s11   <= c_s10;
			tod_s11 <= tod_s10;
		end
		if (adv[11]) begin
			e_s12   <= e_prod[DIV_E_SH +: E_W];
			bd_s12  <= bd_s11;
			c_s12   <= c_s11;
			tod_s12 <= tod_s11;
		end
		if (adv[12]) begin
			p_s13   <= P_W'(e_s12) * P_W'(MON_NUM);
			e_s13   <= e_s12;
			bd_s13  <= bd_s12;
			c_s13   <= c_s12;
			tod_s13 <= tod_s12;
		end
		if (adv[13]) begin
			dom_s14   <= DOM_W'(bd_s13 - BD_W'(f_n));
			month_s14 <= mon_n;
			year_s14  <= YEAR_W'(c_s13 - C_W'(YEAR_BASE))
				+ YEAR_W'(mon_n == MON_W'(1) || mon_n == MON_W'(2));
			tod_s14   <= tod_s13;
		end
	end

	assign out_valid    = vld_q[NUM_STAGES-1];
	assign hours        = tod_s14.hr;
	assign minutes      = tod_s14.mn;
	assign second_units = tod_s14.su;
	assign year         = year_s14;
	assign month        = month_s14;
	assign day_of_month = dom_s14;

endmodule

@@ sim/gps_week_time_to_utc_date_unit_tb.sv @@
`timescale 1ns / 1ps
// gps_week_time_to_utc_date_unit_tb: self-checking bench for the GPS week time to
// UTC date unit. Directed corner requests, then random ones, with random stalls on
// both sides. Depends on gwtu_pkg and gps_week_time_to_utc_date_unit.

module gps_week_time_to_utc_date_unit_tb;

	import gwtu_pkg::*;

	localparam logic [WS_W-1:0] WS_MAX = 32'd2477264895;
	localparam longint WEEK_S = 604800;
	localparam longint DAY_S = 86400;
	localparam longint HOUR_S = 3600;
	localparam longint MIN_S = 60;
	localparam longint JD_AT_DAY0 = 2447892;
	localparam int RANDOM_REQS = 1334;
	localparam int QUIET_TAIL = 150;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [WS_W-1:0]          ws;
		logic [WSD_W-1:0]         wsd;
		logic signed [LEAP_W-1:0] leap;
	} gps_req_t;

	typedef struct packed {
		logic [HOUR_W-1:0] hr;
		logic [MIN_W-1:0]  mn;
		logic [SU_W-1:0]   su;
		logic [YEAR_W-1:0] yr;
		logic [MON_W-1:0]  mo;
		logic [DOM_W-1:0]  dom;
	} utc_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [WS_W-1:0] week_seconds = '0;
	logic [WSD_W-1:0] week_start_day = '0;
	logic signed [LEAP_W-1:0] leap_seconds = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [HOUR_W-1:0] hours;
	logic [MIN_W-1:0] minutes;
	logic [SU_W-1:0] second_units;
	logic [YEAR_W-1:0] year;
	logic [MON_W-1:0] month;
	logic [DOM_W-1:0] day_of_month;

	gps_req_t gps_times_q[$];
	utc_t utc_due[$];
	gps_req_t req_on_bus;
	utc_t utc_exp;
	int unsigned send_gap = 0;
	int unsigned take_gap = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	gps_week_time_to_utc_date_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.week_seconds(week_seconds),
		.week_start_day(week_start_day),
		.leap_seconds(leap_seconds),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hours(hours),
		.minutes(minutes),
		.second_units(second_units),
		.year(year),
		.month(month),
		.day_of_month(day_of_month)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic utc_t utc_from_gps(gps_req_t r);
		longint one, unit, t, whole, rest, frac, secs, dnum, leap;
		longint h, m, s, jd, w, x, a, b, c, d, e, f, dd, mo, yr;
		utc_t u;
		one = longint'(1) << TOW_FRACTION_BITS;
		unit = 2 * TIME_SECOND_DENOM * one;
		t = longint'(r.ws) * 2 * TIME_SECOND_DENOM + one;
		whole = t / unit;
		rest = t % unit;
		frac = (rest + one) >> (TOW_FRACTION_BITS + 1);
		dnum = longint'(r.wsd);
		leap = longint'($signed(r.leap));
		if (whole >= WEEK_S) begin
			dnum = dnum + 7;
			secs = 0;
		end else begin
			secs = whole;
		end
		secs = secs - leap;
		if (secs < 0) begin
			secs = secs + WEEK_S;
			dnum = dnum - 7;
		end
		dnum = dnum + secs / DAY_S;
		secs = secs % DAY_S;
		h = secs / HOUR_S;
		m = (secs - h * HOUR_S) / MIN_S;
		s = (secs - h * HOUR_S - m * MIN_S) * TIME_SECOND_DENOM + frac;
		// Julian day to Gregorian date, exact rational constants
		jd = dnum + JD_AT_DAY0;
		w = (4 * jd - 7468865) / 146097;
		x = w / 4;
		a = jd + 1 + w - x;
		b = a + 1524;
		c = (20 * b - 2442) / 7305;
		d = (1461 * c) / 4;
		e = ((b - d) * 10000) / 306001;
		f = (306001 * e) / 10000;
		dd = b - d - f;
		mo = e - 1;
		if (mo > 12)
			mo = mo - 12;
		yr = c - 4716;
		if (mo == 1 || mo == 2)
			yr = yr + 1;
		u.hr = h[HOUR_W-1:0];
		u.mn = m[MIN_W-1:0];
		u.su = s[SU_W-1:0];
		u.yr = yr[YEAR_W-1:0];
		u.mo = mo[MON_W-1:0];
		u.dom = dd[DOM_W-1:0];
		return u;
	endfunction

	// stalls come in alternating stretches and stop near the end
	function automatic bit stall_phase();
		return gps_times_q.size() >= QUIET_TAIL && (gps_times_q.size() / 200) % 2 == 0;
	endfunction

	task automatic add_gps(input logic [WS_W-1:0] ws, input logic [WSD_W-1:0] wsd,
			input logic signed [LEAP_W-1:0] lp);
		gps_req_t r;
		r.ws = ws;
		r.wsd = wsd;
		r.leap = lp;
		gps_times_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				utc_due.push_back(utc_from_gps(req_on_bus));
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap = send_gap - 1;
					in_valid <= 1'b0;
				end else if (stall_phase() && $urandom_range(7) == 0) begin
					send_gap = $urandom_range(9, 0);
					in_valid <= 1'b0;
				end else if (gps_times_q.size() > 0) begin
					req_on_bus = gps_times_q.pop_front();
					in_valid <= 1'b1;
					week_seconds <= req_on_bus.ws;
					week_start_day <= req_on_bus.wsd;
					leap_seconds <= req_on_bus.leap;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (utc_due.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: result with no request pending: %0d:%0d su=%0d %0d-%0d-%0d",
							$realtime, hours, minutes, second_units, year, month,
							day_of_month);
					mismatch_count = mismatch_count + 1;
				end else begin
					utc_exp = utc_due.pop_front();
					if (utc_exp.hr !== hours || utc_exp.mn !== minutes ||
							utc_exp.su !== second_units || utc_exp.yr !== year ||
							utc_exp.mo !== month || utc_exp.dom !== day_of_month) begin
						if (mismatch_count < MAX_REPORTS)
							$display("%0t: exp %0d:%0d su=%0d %0d-%0d-%0d got %0d:%0d su=%0d %0d-%0d-%0d",
								$realtime, utc_exp.hr, utc_exp.mn, utc_exp.su, utc_exp.yr,
								utc_exp.mo, utc_exp.dom, hours, minutes, second_units, year,
								month, day_of_month);
						mismatch_count = mismatch_count + 1;
					end
				end
			end
			if (take_gap > 0) begin
				take_gap = take_gap - 1;
				out_ready <= 1'b0;
			end else if (stall_phase() && $urandom_range(7) == 0) begin
				take_gap = $urandom_range(9, 0);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		logic [19:0] whole_s;
		logic [11:0] frac_s;
		logic [WS_W-1:0] ws;
		logic [WSD_W-1:0] wsd;
		logic signed [LEAP_W-1:0] lp;

		add_gps('0, '0, 8'sd0);
		add_gps(WS_MAX, 16'hFFFF, -8'sd128);
		add_gps(WS_MAX, 16'hFFFF, 8'sd127);
		add_gps(32'd604800 << 12, 16'd100, 8'sd18);
		add_gps((32'd604800 << 12) - 1, 16'd100, 8'sd0);
		add_gps(32'd604799 << 12, 16'd100, 8'sd0);
		add_gps(32'd5 << 12, 16'd0, 8'sd18);
		add_gps('0, 16'd0, 8'sd1);
		add_gps((32'd604799 << 12) + 2048, 16'hFFFF, -8'sd128);
		add_gps((32'd59 << 12) + 4093, 16'd10, 8'sd0);
		add_gps((32'd86399 << 12) + 4092, 16'd20, 8'sd0);
		add_gps((32'd59 << 12) + 4095, 16'd10, 8'sd0);
		add_gps((32'd10 << 12) + 2048, 16'd30, 8'sd0);
		add_gps(32'd86400 << 12, 16'd3705, 8'sd0);
		add_gps('0, 16'd3712, 8'sd0);
		add_gps(32'h8000_0000, 16'h8000, -8'sd1);
		add_gps(32'h7FFF_FFFF, 16'h7FFF, 8'sd127);
		add_gps(32'd1, 16'd1, 8'sd0);
		add_gps(32'd4095, 16'hFFF8, 8'sd18);

		repeat (RANDOM_REQS) begin
			case ($urandom_range(9, 0))
				6, 7: begin
					whole_s = 20'($urandom_range(604800, 604790));
					frac_s = 12'($urandom_range(4095, 0));
					ws = {whole_s, frac_s};
				end
				8: begin
					whole_s = 20'($urandom_range(604800, 0));
					frac_s = 12'($urandom_range(4095, 4088));
					ws = {whole_s, frac_s};
				end
				9: ws = $urandom_range(200 << 12, 0);
				default: ws = $urandom_range(WS_MAX, 0);
			endcase
			case ($urandom_range(7, 0))
				0: wsd = 16'($urandom_range(20, 0));
				1: wsd = 16'($urandom_range(65535, 65515));
				default: wsd = 16'($urandom_range(65535, 0));
			endcase
			if ($urandom_range(9, 0) < 7)
				lp = 8'($urandom_range(40, 0));
			else
				lp = 8'($urandom_range(255, 0));
			add_gps(ws, wsd, lp);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (gps_times_q.size() > 0 || in_valid || utc_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ gps_week_time_to_utc_date_unit.f @@
design/gwtu_pkg.sv
design/gps_week_time_to_utc_date_unit.sv
sim/gps_week_time_to_utc_date_unit_tb.sv
